/* hdl/dpc_pkg.sv */
// ----------------------------------------------------------------------------
// dpc_pkg
// shared types, widths and register codes for the depth pixel to point block
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int IMAGE_DIM    = 2048;
    localparam int COORD_W      = $clog2(IMAGE_DIM);
    localparam int DEPTH_W      = 16;
    localparam int COLOR_W      = 8;
    localparam int FOCAL_W      = 24;
    localparam int CENTER_W     = 16;
    localparam int FACTOR_W     = 24;
    localparam int BOUND_W      = 32;
    localparam int CROP_FIELD_W = 16;
    localparam int POINT_W      = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 64;

    // raw depth times factor, rounded from Q.24 down to Q.16
    localparam int PROD_W       = DEPTH_W + FACTOR_W;
    localparam int Z_SHIFT      = 8;

    // lateral path widths
    localparam int CENTER_FRAC  = 4;
    localparam int MAG_W        = (COORD_W + CENTER_FRAC > CENTER_W) ?
                                  COORD_W + CENTER_FRAC : CENTER_W;
    localparam int T_W          = MAG_W + FOCAL_W;
    localparam int TL_W         = 20;
    localparam int TH_W         = T_W - TL_W;
    localparam int PHI_W        = POINT_W + TH_W;
    localparam int PLO_W        = POINT_W + TL_W;

    localparam logic [FOCAL_W-1:0]  RST_INV_FOCAL_X  = FOCAL_W'(31960);
    localparam logic [FOCAL_W-1:0]  RST_INV_FOCAL_Y  = FOCAL_W'(31960);
    localparam logic [CENTER_W-1:0] RST_CENTER_X     = CENTER_W'(5120);
    localparam logic [CENTER_W-1:0] RST_CENTER_Y     = CENTER_W'(3840);
    localparam logic [FACTOR_W-1:0] RST_DEPTH_FACTOR = FACTOR_W'(16777);
    localparam logic [BOUND_W-1:0]  RST_MIN_DEPTH    = BOUND_W'(32768);
    localparam logic [BOUND_W-1:0]  RST_MAX_DEPTH    = BOUND_W'(425984);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_INV_FOCAL_X  = 3'd0,
        REG_INV_FOCAL_Y  = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_DEPTH_FACTOR = 3'd4,
        REG_MIN_DEPTH    = 3'd5,
        REG_MAX_DEPTH    = 3'd6,
        REG_CROP_WINDOW  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
        logic [DEPTH_W-1:0] depth_raw;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [POINT_W-1:0]        point_z;
        logic [COLOR_W-1:0]        point_red;
        logic [COLOR_W-1:0]        point_green;
        logic [COLOR_W-1:0]        point_blue;
    } point_t;

    typedef struct packed {
        logic [FOCAL_W-1:0]      inv_focal_x;
        logic [FOCAL_W-1:0]      inv_focal_y;
        logic [CENTER_W-1:0]     center_x;
        logic [CENTER_W-1:0]     center_y;
        logic [FACTOR_W-1:0]     depth_factor;
        logic [BOUND_W-1:0]      min_depth;
        logic [BOUND_W-1:0]      max_depth;
        logic [CROP_FIELD_W-1:0] row_hi;
        logic [CROP_FIELD_W-1:0] row_lo;
        logic [CROP_FIELD_W-1:0] col_hi;
        logic [CROP_FIELD_W-1:0] col_lo;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

endpackage

/* hdl/dpc_cfg.sv */
// ----------------------------------------------------------------------------
// dpc_cfg
// configuration register file, plain indexed write port
// ----------------------------------------------------------------------------
module dpc_cfg
    import dpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_addr)
                REG_INV_FOCAL_X:  cfg_next.inv_focal_x  = cfg_data[FOCAL_W-1:0];
                REG_INV_FOCAL_Y:  cfg_next.inv_focal_y  = cfg_data[FOCAL_W-1:0];
                REG_CENTER_X:     cfg_next.center_x     = cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:     cfg_next.center_y     = cfg_data[CENTER_W-1:0];
                REG_DEPTH_FACTOR: cfg_next.depth_factor = cfg_data[FACTOR_W-1:0];
                REG_MIN_DEPTH:    cfg_next.min_depth    = cfg_data[BOUND_W-1:0];
                REG_MAX_DEPTH:    cfg_next.max_depth    = cfg_data[BOUND_W-1:0];
                REG_CROP_WINDOW:
                begin
                    cfg_next.col_lo = cfg_data[CROP_FIELD_W-1:0];
                    cfg_next.col_hi = cfg_data[2*CROP_FIELD_W-1:CROP_FIELD_W];
                    cfg_next.row_lo = cfg_data[3*CROP_FIELD_W-1:2*CROP_FIELD_W];
                    cfg_next.row_hi = cfg_data[4*CROP_FIELD_W-1:3*CROP_FIELD_W];
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_focal_x  <= RST_INV_FOCAL_X;
            cfg_reg.inv_focal_y  <= RST_INV_FOCAL_Y;
            cfg_reg.center_x     <= RST_CENTER_X;
            cfg_reg.center_y     <= RST_CENTER_Y;
            cfg_reg.depth_factor <= RST_DEPTH_FACTOR;
            cfg_reg.min_depth    <= RST_MIN_DEPTH;
            cfg_reg.max_depth    <= RST_MAX_DEPTH;
            cfg_reg.row_hi       <= '0;
            cfg_reg.row_lo       <= '0;
            cfg_reg.col_hi       <= '0;
            cfg_reg.col_lo       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/dpc_lateral.sv */
// ----------------------------------------------------------------------------
// dpc_lateral
// four-stage lateral coordinate pipe: offset, scale by 1/f, scale by z, round
// ----------------------------------------------------------------------------
module dpc_lateral
    import dpc_pkg::*;
(
    input  logic                       clk,
    input  logic [COORD_W-1:0]         coord,
    input  logic [CENTER_W-1:0]        center,
    input  logic [FOCAL_W-1:0]         inv_focal,
    input  logic [POINT_W-1:0]         depth,
    output logic signed [POINT_W-1:0]  coord_out
);

    localparam int LO_W  = PLO_W + 1;
    localparam int SUM_W = PHI_W + 1;
    localparam int R_W   = SUM_W - Z_SHIFT;
    localparam int RND   = TL_W + Z_SHIFT - 1;

    localparam logic [POINT_W-1:0] POS_MAX = {1'b0, {(POINT_W-1){1'b1}}};
    localparam logic [POINT_W-1:0] NEG_MIN = {1'b1, {(POINT_W-1){1'b0}}};

    logic [MAG_W-1:0]   pos_q;
    logic [MAG_W-1:0]   ctr_q;
    logic               neg_s1;
    logic [MAG_W-1:0]   mag_s1;

    logic [MAG_W-1:0]   mag_reg;
    logic               neg1_reg;
    logic [T_W-1:0]     t_reg;
    logic               neg2_reg;
    logic [PHI_W-1:0]   phi_reg;
    logic [PLO_W-1:0]   plo_reg;
    logic               neg3_reg;
    logic [POINT_W-1:0] out_reg;

    logic [LO_W-1:0]    lo_sum;
    logic [SUM_W-1:0]   full_sum;
    logic [R_W-1:0]     mag_r;
    logic               over;
    logic [POINT_W-1:0] out_next;

    // stage 1: signed offset from principal point
    always_comb
    begin
        pos_q  = MAG_W'({coord, {CENTER_FRAC{1'b0}}});
        ctr_q  = MAG_W'(center);
        neg_s1 = pos_q < ctr_q;
        mag_s1 = neg_s1 ? (ctr_q - pos_q) : (pos_q - ctr_q);
    end

    // stage 4: round half away from zero, saturate, apply sign
    always_comb
    begin
        lo_sum   = LO_W'(plo_reg) + (LO_W'(1) << RND);
        full_sum = SUM_W'(phi_reg) + SUM_W'(lo_sum >> TL_W);
        mag_r    = full_sum[SUM_W-1:Z_SHIFT];
        over     = |mag_r[R_W-1:POINT_W-1];
        if (neg3_reg)
        begin
            out_next = over ? NEG_MIN : (POINT_W'(0) - mag_r[POINT_W-1:0]);
        end
        else
        begin
            out_next = over ? POS_MAX : mag_r[POINT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_s1;
        neg1_reg <= neg_s1;
        t_reg    <= T_W'(mag_reg) * T_W'(inv_focal);
        neg2_reg <= neg1_reg;
        phi_reg  <= PHI_W'(depth) * PHI_W'(t_reg[T_W-1:TL_W]);
        plo_reg  <= PLO_W'(depth) * PLO_W'(t_reg[TL_W-1:0]);
        neg3_reg <= neg2_reg;
        out_reg  <= out_next;
    end

    assign coord_out = out_reg;

endmodule

/* hdl/depth_pixel_to_point_cloud_top.sv */
// ----------------------------------------------------------------------------
// depth_pixel_to_point_cloud_top
// pinhole back-projection of depth pixels into colored 3d points
// ----------------------------------------------------------------------------
// Takes one pixel per clock, every clock: busy is always low. A pixel accepted
// at one edge yields its point, if any, with done high for one cycle, once it
// has passed the four register stages of the lateral multiply chain (offset,
// scale by 1/f, scale by z, round). Pixels outside the crop window or outside
// the depth bounds produce no transaction. Results cannot be held off.
// Configuration writes take effect at the next edge and are meant to be made
// while no pixel is in flight.
module depth_pixel_to_point_cloud_top
    import dpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pixel_t                pixel,
    output logic                  done,
    output point_t                point,
    input  logic                  cfg_wr,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                cfg;
    logic                accept;
    logic                crop_ok;

    logic                v1_reg;
    logic [PROD_W-1:0]   prod_reg;
    color_t              col1_reg;

    logic [PROD_W:0]     z_round;
    logic [POINT_W:0]    z_wide;
    logic [POINT_W-1:0]  z_s2;

    logic                v2_reg;
    logic [POINT_W-1:0]  z2_reg;
    color_t              col2_reg;

    logic                v3_reg;
    logic [POINT_W-1:0]  z3_reg;
    color_t              col3_reg;

    logic                v4_reg;
    logic [POINT_W-1:0]  z4_reg;
    color_t              col4_reg;

    logic signed [POINT_W-1:0] x_out;
    logic signed [POINT_W-1:0] y_out;

    dpc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // column and row above the image cannot be encoded in the coordinate width
    assign crop_ok = (CROP_FIELD_W'(pixel.pixel_col) > cfg.col_lo)
                  && (CROP_FIELD_W'(pixel.pixel_col) < cfg.col_hi)
                  && (CROP_FIELD_W'(pixel.pixel_row) > cfg.row_lo)
                  && (CROP_FIELD_W'(pixel.pixel_row) < cfg.row_hi);

    always_comb
    begin
        z_round = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(1 << (Z_SHIFT - 1));
        z_wide  = (POINT_W+1)'(z_round >> Z_SHIFT);
        z_s2    = z_wide[POINT_W] ? {POINT_W{1'b1}} : z_wide[POINT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept && crop_ok;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && (z2_reg > cfg.min_depth) && (z2_reg < cfg.max_depth);
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(pixel.depth_raw) * PROD_W'(cfg.depth_factor);
        col1_reg <= '{red: pixel.red, green: pixel.green, blue: pixel.blue};
        z2_reg   <= z_s2;
        col2_reg <= col1_reg;
        z3_reg   <= z2_reg;
        col3_reg <= col2_reg;
        z4_reg   <= z3_reg;
        col4_reg <= col3_reg;
    end

    dpc_lateral u_lat_x (
        .clk       (clk),
        .coord     (pixel.pixel_col),
        .center    (cfg.center_x),
        .inv_focal (cfg.inv_focal_x),
        .depth     (z2_reg),
        .coord_out (x_out)
    );

    dpc_lateral u_lat_y (
        .clk       (clk),
        .coord     (pixel.pixel_row),
        .center    (cfg.center_y),
        .inv_focal (cfg.inv_focal_y),
        .depth     (z2_reg),
        .coord_out (y_out)
    );

    assign done              = v4_reg;
    assign point.point_x     = x_out;
    assign point.point_y     = y_out;
    assign point.point_z     = z4_reg;
    assign point.point_red   = col4_reg.red;
    assign point.point_green = col4_reg.green;
    assign point.point_blue  = col4_reg.blue;

endmodule

/* hdl/dpc_checker.sv */
// ----------------------------------------------------------------------------
// dpc_checker
// port-level checks on the point pipeline, bound to the top level
// ----------------------------------------------------------------------------
module dpc_checker
    import dpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  pixel_t                pixel,
    input  logic                  done,
    input  point_t                point
);

    // every point traces back to an accepted pixel
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("point without an accepted pixel");

    // color travels with its own pixel
    a_color_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (point.point_red == $past(pixel.red, 4))
              && (point.point_green == $past(pixel.green, 4))
              && (point.point_blue == $past(pixel.blue, 4)))
        else $error("point color does not match its pixel");

    // depth passed a strict lower bound, so it is never zero
    a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (point.point_z != '0))
        else $error("emitted point with zero depth");

    // zero raw depth rounds to zero depth and fails the lower bound
    a_zero_window: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (pixel.depth_raw == '0)) |-> ##4 !done)
        else $error("zero raw depth produced a point");

endmodule

bind depth_pixel_to_point_cloud_top dpc_checker u_dpc_checker (.*);
